// ===== rtl/isas_pkg.sv =====
// Shared types, constants and address classification functions for the
// IPv6 source address selector. No dependencies.
`default_nettype none

package isas_pkg;

    localparam logic [3:0] SCOPE_LINK   = 4'd2;
    localparam logic [3:0] SCOPE_SITE   = 4'd5;
    localparam logic [3:0] SCOPE_GLOBAL = 4'd14;

    localparam logic [1:0] ST_DEPRECATED = 2'd1;
    localparam logic [1:0] ST_TENTATIVE  = 2'd2;

    localparam logic       REQ_WRITE = 1'b0;
    localparam logic       REQ_QUERY = 1'b1;

    localparam logic [7:0] FULL_MATCH = 8'd128;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  entry_index;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [1:0]  addr_state;
        logic [7:0]  prefix_len;
    } isas_req_t;

    typedef struct packed {
        logic       found;
        logic [3:0] source_index;
    } isas_rsp_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [1:0]  state;
        logic [7:0]  prefix;
    } isas_entry_t;

    typedef struct packed {
        logic       skip;
        logic       same;
        logic [3:0] scope;
        logic       dep;
        logic       lab;
        logic [7:0] clen;
    } isas_attr_t;

    function automatic logic is_loopback(input logic [63:0] hi, input logic [63:0] lo);
        return (hi == 64'd0) && (lo == 64'd1);
    endfunction

    function automatic logic is_v4map(input logic [63:0] hi, input logic [63:0] lo);
        return (hi == 64'd0) && (lo[63:32] == 32'h0000_FFFF);
    endfunction

    function automatic logic [3:0] scope_of(input logic [63:0] hi, input logic [63:0] lo);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [3:0] s;
        b0 = hi[63:56];
        b1 = hi[55:48];
        if (b0 == 8'hFF) begin
            s = b1[3:0];
        end else if ((b0 == 8'hFE && b1[7:6] == 2'b10) || is_loopback(hi, lo)) begin
            s = SCOPE_LINK;
        end else if (b0 == 8'hFE && b1[7:6] == 2'b11) begin
            s = SCOPE_SITE;
        end else if (is_v4map(hi, lo) && (lo[31:24] == 8'd127 ||
                     (lo[31:24] == 8'd169 && lo[23:16] == 8'd254))) begin
            s = SCOPE_LINK;
        end else begin
            s = SCOPE_GLOBAL;
        end
        return s;
    endfunction

    function automatic logic [3:0] label_of(input logic [63:0] hi, input logic [63:0] lo);
        logic [3:0] l;
        if (is_loopback(hi, lo)) begin
            l = 4'd0;
        end else if (is_v4map(hi, lo)) begin
            l = 4'd4;
        end else if (hi == 64'd0 && lo[63:32] == 32'd0) begin
            l = 4'd3;
        end else if (hi[63:32] == 32'h2001_0000) begin
            l = 4'd5;
        end else if (hi[63:48] == 16'h2002) begin
            l = 4'd2;
        end else if (hi[63:48] == 16'h3FFE) begin
            l = 4'd12;
        end else if (hi[63:56] == 8'hFE && hi[55:54] == 2'b11) begin
            l = 4'd11;
        end else if (hi[63:57] == 7'b1111_110) begin
            l = 4'd13;
        end else begin
            l = 4'd1;
        end
        return l;
    endfunction

    function automatic logic [2:0] lz8(input logic [7:0] b);
        logic [2:0] n;
        casez (b)
            8'b1???????: n = 3'd0;
            8'b01??????: n = 3'd1;
            8'b001?????: n = 3'd2;
            8'b0001????: n = 3'd3;
            8'b00001???: n = 3'd4;
            8'b000001??: n = 3'd5;
            8'b0000001?: n = 3'd6;
            default:     n = 3'd7;
        endcase
        return n;
    endfunction

    // True when candidate a is strictly better than the current best b.
    function automatic logic better(input isas_attr_t a, input isas_attr_t b,
                                    input logic [3:0] zd);
        logic w;
        if (a.same != b.same) begin
            w = a.same;
        end else if (a.scope != b.scope) begin
            if (a.scope < b.scope) begin
                w = !(a.scope < zd);
            end else begin
                w = (b.scope < zd);
            end
        end else if (a.dep != b.dep) begin
            w = !a.dep;
        end else if (a.lab != b.lab) begin
            w = a.lab;
        end else begin
            w = (a.clen > b.clen);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/isas_cand_mem.sv =====
// Candidate table storage: one write port and one registered read port.
// Depends on isas_pkg for the entry type.
`default_nettype none

module isas_cand_mem
    import isas_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire isas_entry_t   wdata,
    input  wire logic [AW-1:0] raddr,
    output isas_entry_t        rdata
);

    isas_entry_t mem_reg [DEPTH];
    isas_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/isas_match.sv =====
// Candidate evaluation unit: classifies one entry against the destination and
// finishes the common prefix length. Depends on isas_pkg.
`default_nettype none

module isas_match
    import isas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        load,
    input  wire isas_entry_t cand,
    input  wire logic [63:0] dest_hi,
    input  wire logic [63:0] dest_lo,
    input  wire logic        dest_map,
    input  wire logic [3:0]  dest_scope,
    input  wire logic [3:0]  dest_label,
    output isas_attr_t       attr
);

    logic        skip_reg;
    logic        same_reg;
    logic [3:0]  scope_reg;
    logic        dep_reg;
    logic        lab_reg;
    logic [7:0]  prefix_reg;
    logic [15:0] nz_reg;
    logic [2:0]  blz_reg [16];

    logic [127:0] diff;
    logic [3:0]   cscope;
    logic [7:0]   clen;

    assign diff   = {cand.hi ^ dest_hi, cand.lo ^ dest_lo};
    assign cscope = scope_of(cand.hi, cand.lo);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            skip_reg   <= (cand.state == ST_TENTATIVE) ||
                          (is_v4map(cand.hi, cand.lo) != dest_map) ||
                          (cand.hi[63:56] == 8'hFF) ||
                          (cand.hi == 64'd0 && cand.lo == 64'd0) ||
                          (cscope < dest_scope);
            same_reg   <= (diff == 128'd0);
            scope_reg  <= cscope;
            dep_reg    <= (cand.state == ST_DEPRECATED);
            lab_reg    <= (label_of(cand.hi, cand.lo) == dest_label);
            prefix_reg <= cand.prefix;
            for (int k = 0; k < 16; k++)
            begin
                nz_reg[k]  <= (diff[127-8*k -: 8] != 8'd0);
                blz_reg[k] <= lz8(diff[127-8*k -: 8]);
            end
        end
    end

    always_comb
    begin
        clen = FULL_MATCH;
        for (int k = 15; k >= 0; k--)
        begin
            if (nz_reg[k])
            begin
                clen = 8'(8 * k) + {5'd0, blz_reg[k]};
            end
        end
    end

    always_comb
    begin
        attr.skip  = skip_reg;
        attr.same  = same_reg;
        attr.scope = scope_reg;
        attr.dep   = dep_reg;
        attr.lab   = lab_reg;
        attr.clen  = (prefix_reg < clen) ? prefix_reg : clen;
    end

endmodule

`default_nettype wire

// ===== rtl/ipv6_source_address_selector_top.sv =====
// Top level of the IPv6 source address selector: sequencer, best-candidate
// register and result register. Depends on isas_pkg, isas_cand_mem, isas_match.
//
//   channel | signals                        | direction
//   request | req_valid, req_stall, req_data | in
//   result  | rsp_valid, rsp_stall, rsp_data | out
//   config  | cfg_we, cfg_wdata              | in
//
// A write request does not start a scan. In a query each of the n scanned
// candidates passes read, classify and decide steps through the shared
// evaluation unit. Reset clears the count register and the sequencer; the
// table is undefined until written. A stalled result holds the sequencer in
// its final step until it is taken.
`default_nettype none

module ipv6_source_address_selector_top
    import isas_pkg::*;
#(
    parameter int MAX_CANDIDATES = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire isas_req_t  req_data,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output isas_rsp_t       rsp_data,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata
);

    localparam int IW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW = $clog2(MAX_CANDIDATES + 1);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_ATTR, S_DECIDE, S_DONE} state_t;

    state_t      state_reg;
    logic [4:0]  count_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic        have_reg;
    logic [IW-1:0] best_reg;
    isas_attr_t  best_attr_reg;
    logic [63:0] dest_hi_reg;
    logic [63:0] dest_lo_reg;
    logic        dest_map_reg;
    logic [3:0]  dest_scope_reg;
    logic [3:0]  dest_label_reg;
    logic        rsp_valid_reg;
    isas_rsp_t   rsp_data_reg;

    logic        accept;
    logic        mem_we;
    isas_entry_t wentry;
    isas_entry_t rentry;
    isas_attr_t  attr;
    logic [CW-1:0] n_next;
    logic [CW-1:0] i_next;
    logic        take;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign mem_we    = accept && (req_data.req_type == REQ_WRITE) &&
                       (32'(req_data.entry_index) < MAX_CANDIDATES);
    assign wentry    = '{hi: req_data.addr_hi, lo: req_data.addr_lo,
                         state: req_data.addr_state, prefix: req_data.prefix_len};
    assign n_next    = (32'(count_reg) > MAX_CANDIDATES) ? CW'(MAX_CANDIDATES)
                                                         : CW'(count_reg);
    assign i_next    = i_reg + CW'(1);
    assign take      = !attr.skip && (!have_reg || better(attr, best_attr_reg, dest_scope_reg));

    isas_cand_mem #(
        .DEPTH (MAX_CANDIDATES),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (IW'(req_data.entry_index)),
        .wdata (wentry),
        .raddr (i_reg[IW-1:0]),
        .rdata (rentry)
    );

    isas_match u_match (
        .clk        (clk),
        .load       (state_reg == S_ATTR),
        .cand       (rentry),
        .dest_hi    (dest_hi_reg),
        .dest_lo    (dest_lo_reg),
        .dest_map   (dest_map_reg),
        .dest_scope (dest_scope_reg),
        .dest_label (dest_label_reg),
        .attr       (attr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= 5'd0;
            n_reg          <= '0;
            i_reg          <= '0;
            have_reg       <= 1'b0;
            best_reg       <= '0;
            best_attr_reg  <= '0;
            dest_hi_reg    <= 64'd0;
            dest_lo_reg    <= 64'd0;
            dest_map_reg   <= 1'b0;
            dest_scope_reg <= 4'd0;
            dest_label_reg <= 4'd0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (rsp_valid_reg && !rsp_stall && state_reg != S_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && req_data.req_type == REQ_QUERY)
                    begin
                        dest_hi_reg    <= req_data.addr_hi;
                        dest_lo_reg    <= req_data.addr_lo;
                        dest_map_reg   <= is_v4map(req_data.addr_hi, req_data.addr_lo);
                        dest_scope_reg <= scope_of(req_data.addr_hi, req_data.addr_lo);
                        dest_label_reg <= label_of(req_data.addr_hi, req_data.addr_lo);
                        n_reg          <= n_next;
                        i_reg          <= '0;
                        have_reg       <= 1'b0;
                        best_reg       <= '0;
                        state_reg      <= (n_next == '0) ? S_DONE : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_ATTR;
                end
                S_ATTR:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (take)
                    begin
                        have_reg      <= 1'b1;
                        best_reg      <= i_reg[IW-1:0];
                        best_attr_reg <= attr;
                    end
                    i_reg     <= i_next;
                    state_reg <= (i_next == n_reg) ? S_DONE : S_READ;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg         <= 1'b1;
                        rsp_data_reg.found    <= have_reg;
                        rsp_data_reg.source_index <= have_reg ? 4'(best_reg) : 4'd0;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> (i_reg < n_reg))
        else $error("scan index past candidate count");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_data_reg.found) |-> (rsp_data_reg.source_index == 4'd0))
        else $error("not-found result carries a nonzero index");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rsp_valid_reg && rsp_stall) |=> (state_reg == S_DONE))
        else $error("result overwritten while stalled");

    a_write_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_data.req_type == REQ_WRITE) |=> (state_reg == S_IDLE))
        else $error("write request started a scan");

endmodule

`default_nettype wire
